FILE: sv/multichannel_moving_average_core_macros.svh
// Assertion macros for the multichannel moving average core.
// Used by the controller; needs nothing else.
`ifndef MULTICHANNEL_MOVING_AVERAGE_CORE_MACROS_SVH
`define MULTICHANNEL_MOVING_AVERAGE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define MMA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mma: same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define MMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mma: next-cycle check failed");

`endif

FILE: sv/mma_pkg.sv
// Shared types and constants of the multichannel moving average core.
// No dependencies.
`default_nettype none

package mma_pkg;

  // Fixed field widths
  localparam int CHANNEL_W   = 2;
  localparam int AVG_W       = 36;
  localparam int WLEN_W      = 11;
  localparam int OFFSET_W    = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NORMALIZE     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SUM_OFFSET    = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_FINISH
  } mma_state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic sum;
    logic div_start;
    logic load_out;
  } mma_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic normalize;
    logic div_busy;
    logic out_free;
  } mma_sts_t;

endpackage

`default_nettype wire

FILE: sv/mma_if.sv
// Stream interfaces for the sample input and the result output.
// Depends on mma_pkg.
`default_nettype none

interface mma_in_if
  import mma_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [CHANNEL_W-1:0]          channel;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mma_out_if
  import mma_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_W-1:0]    channel_out;
  logic signed [AVG_W-1:0] average;

  modport source (output valid, output channel_out, output average, input ready);
  modport sink   (input valid, input channel_out, input average, output ready);
endinterface

`default_nettype wire

FILE: sv/multichannel_moving_average_core.sv
// An accepted item goes from ST_IDLE to ST_SUM, then to ST_DIV with normalize set
// (TOT_W = 33 at default widths, one quotient bit per cycle in the divider), then to
// ST_FINISH, which loads the output register once it is free. The controller handles
// one item at a time around the history read-modify-write.
// Reset (synchronous, active high): clears control, config and per-channel state, then
// sweeps the history memory to zero with ready low; config writes are taken whenever reset is low.
`default_nettype none

module multichannel_moving_average_core
  import mma_pkg::*;
#(
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_WINDOW   = 1024,
  parameter int SAMPLE_BITS  = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  mma_in_if.sink                      in_ch,
  mma_out_if.source                   out_ch
);

  mma_cmd_t cmd;
  mma_sts_t sts;
  logic     in_ready;

  // Controller
  mma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // Datapath
  mma_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_channel  (in_ch.channel),
    .in_sample   (in_ch.sample),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_channel (out_ch.channel_out),
    .out_average (out_ch.average)
  );

endmodule

`default_nettype wire

FILE: sv/mma_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero. Depends on nothing.
`default_nettype none

module mma_div #(
  parameter int DIVIDEND_W = 33,
  parameter int DIVISOR_W  = 11
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic signed [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]         divisor,
  output logic                              busy,
  output logic signed [DIVIDEND_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvsr;
  logic                  neg;
  logic [CNT_W-1:0]      cnt;

  logic [DIVIDEND_W-1:0] mag;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;

  // Magnitude of the dividend and one restoring step
  always_comb begin
    mag     = dividend[DIVIDEND_W-1] ? (-dividend) : dividend;
    shifted = {rem, quo[DIVIDEND_W-1]};
    diff    = shifted - {1'b0, dvsr};
  end

  // Control: bit counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DIVIDEND_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Operands, partial remainder and quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= mag;
      rem  <= '0;
      dvsr <= divisor;
      neg  <= dividend[DIVIDEND_W-1];
    end else if (busy) begin
      if (!diff[DIVISOR_W]) begin
        rem <= diff[DIVISOR_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DIVISOR_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  // Restore the sign
  assign quotient = neg ? -signed'(quo) : signed'(quo);

endmodule

`default_nettype wire

FILE: sv/mma_datapath.sv
// Datapath: configuration registers, history memory with clearing sweep,
// per-channel positions and sums, divider and output register.
// Depends on mma_pkg and mma_div.
`default_nettype none

module mma_datapath
  import mma_pkg::*;
#(
  parameter int MAX_CHANNELS = 4,
  parameter int MAX_WINDOW   = 1024,
  parameter int SAMPLE_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mma_cmd_t                      cmd,
  output mma_sts_t                           sts,
  input  wire logic                          cfg_write,
  input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data,
  input  wire logic [CHANNEL_W-1:0]          in_channel,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [CHANNEL_W-1:0]               out_channel,
  output logic signed [AVG_W-1:0]            out_average
);

  localparam int DEPTH    = MAX_CHANNELS * MAX_WINDOW;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int POS_W    = $clog2(MAX_WINDOW);
  localparam int LEN_W    = $clog2(MAX_WINDOW + 1);
  localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SUM_W    = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
  localparam int TOT_W    = ((SUM_W > OFFSET_W) ? SUM_W : OFFSET_W) + 1;

  // Configuration registers
  logic [WLEN_W-1:0]          window_length;
  logic                       normalize;
  logic signed [OFFSET_W-1:0] sum_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WLEN_W'(1);
      normalize     <= 1'b0;
      sum_offset    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data[WLEN_W-1:0];
        REG_NORMALIZE:     normalize     <= cfg_data[0];
        REG_SUM_OFFSET:    sum_offset    <= signed'(cfg_data[OFFSET_W-1:0]);
        default: ;
      endcase
    end
  end

  // Effective window length: zero acts as one, clamp at the maximum
  logic [LEN_W-1:0] eff_len;

  always_comb begin
    if (window_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(window_length);
    end
  end

  // Per-channel state
  logic [POS_W-1:0]        write_position [MAX_CHANNELS];
  logic signed [SUM_W-1:0] window_sum     [MAX_CHANNELS];

  // Captured item
  logic [CHANNEL_W-1:0]          item_ch;
  logic signed [SAMPLE_BITS-1:0] item_sample;
  logic                          item_in_range;
  logic [ADDR_W-1:0]             item_addr;
  logic [POS_W-1:0]              item_pos;

  // Address of the slot to replace, from the incoming transaction
  logic [CH_IDX_W-1:0] in_idx;
  logic                in_range;
  logic [POS_W-1:0]    pos_raw;
  logic [POS_W-1:0]    pos_cur;
  logic [ADDR_W-1:0]   in_addr;

  always_comb begin
    in_idx   = CH_IDX_W'(in_channel);
    in_range = 32'(in_channel) < 32'(MAX_CHANNELS);
    pos_raw  = write_position[in_idx];
    pos_cur  = (LEN_W'(pos_raw) >= eff_len) ? '0 : pos_raw;
    in_addr  = ADDR_W'(in_channel) * ADDR_W'(MAX_WINDOW) + ADDR_W'(pos_cur);
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_ch       <= in_channel;
      item_sample   <= in_sample;
      item_in_range <= in_range;
      item_addr     <= in_addr;
      item_pos      <= pos_cur;
    end
  end

  // Clearing sweep counter
  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // History memory: one write port, one registered read port
  logic signed [SAMPLE_BITS-1:0] history [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic                          wr_en;
  logic [ADDR_W-1:0]             wr_addr;
  logic signed [SAMPLE_BITS-1:0] wr_data;

  always_comb begin
    wr_en   = cmd.clear || (cmd.sum && item_in_range);
    wr_addr = cmd.clear ? clr_addr : item_addr;
    wr_data = cmd.clear ? '0 : item_sample;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      history[wr_addr] <= wr_data;
    end
    if (cmd.accept) begin
      rd_data <= history[in_addr];
    end
  end

  // Sum update and next write position
  logic [CH_IDX_W-1:0]     item_idx;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [TOT_W-1:0] total_next;
  logic [LEN_W-1:0]        pos_plus;
  logic [POS_W-1:0]        pos_next;

  always_comb begin
    item_idx   = CH_IDX_W'(item_ch);
    sum_next   = window_sum[item_idx] + SUM_W'(item_sample) - SUM_W'(rd_data);
    total_next = item_in_range ? (TOT_W'(sum_offset) + TOT_W'(sum_next)) : '0;
    pos_plus   = LEN_W'(item_pos) + LEN_W'(1);
    pos_next   = (pos_plus >= eff_len) ? '0 : POS_W'(pos_plus);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        write_position[i] <= '0;
        window_sum[i]     <= '0;
      end
    end else if (cmd.sum && item_in_range) begin
      write_position[item_idx] <= pos_next;
      window_sum[item_idx]     <= sum_next;
    end
  end

  logic signed [TOT_W-1:0] total;

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      total <= total_next;
    end
  end

  // Divider for the normalized result
  logic                    div_busy;
  logic signed [TOT_W-1:0] quotient;

  mma_div #(
    .DIVIDEND_W (TOT_W),
    .DIVISOR_W  (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (total_next),
    .divisor  (eff_len),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Output register
  logic signed [TOT_W-1:0] result;
  logic                    out_free;

  always_comb begin
    result   = normalize ? quotient : total;
    out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_channel <= item_ch;
      out_average <= AVG_W'(result);
    end
  end

  // Status back to the controller
  always_comb begin
    sts.clear_done = (clr_addr == ADDR_W'(DEPTH - 1));
    sts.normalize  = normalize;
    sts.div_busy   = div_busy;
    sts.out_free   = out_free;
  end

endmodule

`default_nettype wire

FILE: sv/mma_ctrl.sv
// Controller state machine: clearing sweep, item sequencing, divide wait,
// output hand-off. Depends on mma_pkg and the assertion macro header.
`default_nettype none
`include "multichannel_moving_average_core_macros.svh"

module mma_ctrl
  import mma_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire mma_sts_t sts,
  output mma_cmd_t      cmd
);

  mma_state_t state;
  mma_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = sts.normalize ? ST_DIV : ST_FINISH;
      end
      ST_DIV: begin
        if (!sts.div_busy) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = (state == ST_IDLE);
    cmd.clear     = (state == ST_CLEAR);
    cmd.accept    = (state == ST_IDLE) && in_valid;
    cmd.sum       = (state == ST_SUM);
    cmd.div_start = (state == ST_SUM) && sts.normalize;
    cmd.load_out  = (state == ST_FINISH) && sts.out_free;
  end

  // Divider must be running right after a normalized sum
  `MMA_ASSERT_NEXT(a_div_started, clk, rst, (state == ST_SUM) && sts.normalize, sts.div_busy)
  // No result is handed off while a division is still in flight
  `MMA_ASSERT_IMPL(a_finish_div_idle, clk, rst, state == ST_FINISH, !sts.div_busy)
  // Clearing happens only once, after reset
  `MMA_ASSERT_NEXT(a_no_reclear, clk, rst, state == ST_IDLE, state != ST_CLEAR)

endmodule

`default_nettype wire
